// ----- hw/rtl/wrpf_pkg.sv -----
package wrpf_pkg;

    localparam int ADC_BITS = 14;
    localparam int MAX_WINDOW_SAMPLES = 64;
    localparam logic [ADC_BITS-1:0] SAMPLE_MAX = {ADC_BITS{1'b1}};
    localparam logic [10:0] VOLT_SAT = 11'd2047;

    typedef enum logic [1:0] {
        ACT_SAMPLE = 2'd0,
        ACT_EDGE   = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_REPORT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        REG_SAMPLES  = 3'd0,
        REG_TICKS    = 3'd1,
        REG_DC_DIV   = 3'd2,
        REG_PK_DIV   = 3'd3,
        REG_RMS_DIV  = 3'd4,
        REG_TIMER_HZ = 3'd5
    } reg_index_t;

    // Divider operand selection
    typedef enum logic [2:0] {
        DIV_DC,
        DIV_PK,
        DIV_MS,
        DIV_RMS,
        DIV_PER
    } div_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_UPDATE,
        ST_DC_GO,
        ST_DC_WAIT,
        ST_PK_GO,
        ST_PK_WAIT,
        ST_MS_GO,
        ST_MS_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_RMS_GO,
        ST_RMS_WAIT,
        ST_PER_GO,
        ST_PER_WAIT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     capture;
        logic     update;
        logic     div_start;
        div_sel_t div_sel;
        logic     sqrt_start;
        logic     load_out;
    } ctrl_t;

    typedef struct packed {
        logic     is_report;
        logic     div_done;
        logic     sqrt_done;
    } stat_t;

endpackage

// ----- hw/rtl/wrpf_if.sv -----
interface wrpf_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [13:0] sample_value;
    modport source (output valid, action, sample_value, input ready);
    modport sink (input valid, action, sample_value, output ready);
endinterface

interface wrpf_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] frequency_count;
    logic [10:0] dc_centivolts;
    logic [10:0] vpp_centivolts;
    logic [10:0] vrms_centivolts;
    logic [23:0] sample_period;
    logic        no_signal;
    modport source (output valid, frequency_count, dc_centivolts, vpp_centivolts,
                    vrms_centivolts, sample_period, no_signal, input ready);
    modport sink (input valid, frequency_count, dc_centivolts, vpp_centivolts,
                  vrms_centivolts, sample_period, no_signal, output ready);
endinterface

interface wrpf_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/wrpf_divider.sv -----
// Restoring divider, one quotient bit a cycle; 48-bit dividend, 24-bit divisor.
module wrpf_divider import wrpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] dividend,
    input  logic [23:0] divisor,
    output logic        done,
    output logic [47:0] quotient
);
    logic [47:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] dsr_reg, dsr_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[23:0], quo_reg[47]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = trial - {1'b0, dsr_reg};
                quo_next = {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd47)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ----- hw/rtl/wrpf_isqrt.sv -----
// Digit-by-digit square root, one result bit a cycle over a 48-bit radicand.
module wrpf_isqrt import wrpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [47:0] radicand,
    output logic        done,
    output logic [23:0] root
);
    logic [47:0] x_reg, x_next;
    logic [25:0] rem_reg, rem_next;
    logic [23:0] res_reg, res_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [25:0] trial;
    logic [25:0] sub;

    always_comb
    begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[23:0], x_reg[47:46]};
        sub       = {res_reg, 2'b01};
        if (start)
        begin
            x_next    = radicand;
            rem_next  = '0;
            res_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            x_next = {x_reg[45:0], 2'b00};
            if (trial >= sub)
            begin
                rem_next = trial - sub;
                res_next = {res_reg[22:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                res_next = {res_reg[22:0], 1'b0};
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd23)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    assign done = done_reg;
    assign root = res_reg;
endmodule

// ----- hw/rtl/wrpf_datapath.sv -----
module wrpf_datapath import wrpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  ctrl_t       ctrl,
    output stat_t       stat,
    input  logic [1:0]  in_action,
    input  logic [13:0] in_sample,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,
    output logic [15:0] o_freq,
    output logic [10:0] o_dc,
    output logic [10:0] o_vpp,
    output logic [10:0] o_rms,
    output logic [23:0] o_period,
    output logic        o_nosig
);
    logic [6:0]  spw_reg;
    logic [7:0]  tpw_reg;
    logic [15:0] dcdiv_reg, pkdiv_reg, rmsdiv_reg;
    logic [23:0] clk_hz_reg;

    logic [13:0] min_reg, max_reg;
    logic [34:0] sum_reg;
    logic [6:0]  scnt_reg;
    logic [15:0] ecnt_reg;
    logic [7:0]  tcnt_reg;
    logic [15:0] freq_reg;

    logic [1:0]  act_reg;
    logic [13:0] smp_reg;
    logic [27:0] sq_reg;

    logic [10:0] dc_reg, vpp_reg, rms_reg;
    logic [23:0] per_reg;
    logic [47:0] ms_reg;

    logic [6:0]  n_eff;
    logic        div_start;
    logic [47:0] div_a;
    logic [23:0] div_b;
    logic        div_done;
    logic [47:0] div_q;
    logic        sq_done;
    logic [23:0] sq_root;
    logic [10:0] q_sat;
    logic [14:0] mm_sum;
    logic [22:0] n_f;

    assign n_eff = (spw_reg == 7'd0) ? 7'd1 :
                   (spw_reg > 7'(MAX_WINDOW_SAMPLES)) ? 7'(MAX_WINDOW_SAMPLES) : spw_reg;
    assign mm_sum = {1'b0, max_reg} + {1'b0, min_reg};
    assign n_f    = 23'(n_eff) * 23'(freq_reg);

    function automatic logic [15:0] nz(input logic [15:0] d);
        nz = (d == 16'd0) ? 16'd1 : d;
    endfunction

    always_comb
    begin
        div_a = '0;
        div_b = 24'd1;
        case (ctrl.div_sel)
            DIV_DC:
            begin
                div_a = 48'(mm_sum[14:1]) * 48'd100;
                div_b = 24'(nz(dcdiv_reg));
            end
            DIV_PK:
            begin
                div_a = (max_reg > min_reg) ? 48'(max_reg - min_reg) * 48'd100 : 48'd0;
                div_b = 24'(nz(pkdiv_reg));
            end
            DIV_MS:
            begin
                div_a = 48'(sum_reg) * 48'd10000;
                div_b = 24'(n_eff);
            end
            DIV_RMS:
            begin
                div_a = 48'(sq_root);
                div_b = 24'(nz(rmsdiv_reg));
            end
            DIV_PER:
            begin
                div_a = 48'(clk_hz_reg);
                div_b = (n_f[22:0] == 23'd0) ? 24'd1 : 24'(n_f);
            end
            default: ;
        endcase
    end

    assign q_sat = (div_q > 48'(VOLT_SAT)) ? VOLT_SAT : div_q[10:0];

    wrpf_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    wrpf_isqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.sqrt_start),
        .radicand (ms_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign div_start = ctrl.div_start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spw_reg    <= 7'd50;
            tpw_reg    <= 8'd50;
            dcdiv_reg  <= 16'd5000;
            pkdiv_reg  <= 16'd5050;
            rmsdiv_reg <= 16'd5060;
            clk_hz_reg <= 24'd3000000;
            min_reg    <= SAMPLE_MAX;
            max_reg    <= '0;
            sum_reg    <= '0;
            scnt_reg   <= '0;
            ecnt_reg   <= '0;
            tcnt_reg   <= '0;
            freq_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SAMPLES:  spw_reg    <= cfg_data[6:0];
                    REG_TICKS:    tpw_reg    <= cfg_data[7:0];
                    REG_DC_DIV:   dcdiv_reg  <= cfg_data[15:0];
                    REG_PK_DIV:   pkdiv_reg  <= cfg_data[15:0];
                    REG_RMS_DIV:  rmsdiv_reg <= cfg_data[15:0];
                    REG_TIMER_HZ: clk_hz_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (ctrl.update)
            begin
                unique case (act_reg)
                    ACT_SAMPLE:
                    begin
                        if (smp_reg > max_reg)
                            max_reg <= smp_reg;
                        if (smp_reg < min_reg)
                            min_reg <= smp_reg;
                        if (scnt_reg < n_eff)
                        begin
                            sum_reg  <= sum_reg + 35'(sq_reg);
                            scnt_reg <= scnt_reg + 7'd1;
                        end
                    end
                    ACT_EDGE:
                        if (ecnt_reg != 16'hFFFF)
                            ecnt_reg <= ecnt_reg + 16'd1;
                    ACT_TICK:
                    begin
                        if (tcnt_reg >= tpw_reg)
                        begin
                            freq_reg <= ecnt_reg;
                            min_reg  <= SAMPLE_MAX;
                            max_reg  <= '0;
                            sum_reg  <= '0;
                            scnt_reg <= '0;
                            ecnt_reg <= '0;
                            tcnt_reg <= '0;
                        end
                        else
                            tcnt_reg <= tcnt_reg + 8'd1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            act_reg <= in_action;
            smp_reg <= in_sample;
        end
        sq_reg <= 28'(smp_reg) * 28'(smp_reg);
        if (div_done)
        begin
            unique case (ctrl.div_sel)
                DIV_DC:  dc_reg  <= q_sat;
                DIV_PK:  vpp_reg <= q_sat;
                DIV_MS:  ms_reg  <= div_q;
                DIV_RMS: rms_reg <= q_sat;
                DIV_PER: per_reg <= div_q[23:0];
                default: ;
            endcase
        end
        if (ctrl.load_out)
        begin
            o_freq   <= freq_reg;
            o_dc     <= dc_reg;
            o_vpp    <= vpp_reg;
            o_rms    <= rms_reg;
            o_period <= (freq_reg == 16'd0) ? 24'd0 : per_reg;
            o_nosig  <= (freq_reg == 16'd0);
        end
    end

    assign stat.is_report = (act_reg == ACT_REPORT);
    assign stat.div_done  = div_done && !div_start;
    assign stat.sqrt_done = sq_done;
endmodule

// ----- hw/rtl/wrpf_ctrl.sv -----
module wrpf_ctrl import wrpf_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output ctrl_t ctrl
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_SQUARE;
            ST_SQUARE:   state_next = ST_UPDATE;
            ST_UPDATE:   state_next = stat.is_report ? ST_DC_GO : ST_IDLE;
            ST_DC_GO:    state_next = ST_DC_WAIT;
            ST_DC_WAIT:  if (stat.div_done) state_next = ST_PK_GO;
            ST_PK_GO:    state_next = ST_PK_WAIT;
            ST_PK_WAIT:  if (stat.div_done) state_next = ST_MS_GO;
            ST_MS_GO:    state_next = ST_MS_WAIT;
            ST_MS_WAIT:  if (stat.div_done) state_next = ST_SQ_GO;
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:  if (stat.sqrt_done) state_next = ST_RMS_GO;
            ST_RMS_GO:   state_next = ST_RMS_WAIT;
            ST_RMS_WAIT: if (stat.div_done) state_next = ST_PER_GO;
            ST_PER_GO:   state_next = ST_PER_WAIT;
            ST_PER_WAIT: if (stat.div_done) state_next = ST_OUT;
            ST_OUT:      if (!ov_reg || out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl            = '0;
        ctrl.div_sel    = DIV_DC;
        in_ready        = (state_reg == ST_IDLE);
        ctrl.capture    = in_valid && in_ready;
        unique case (state_reg)
            ST_UPDATE:                ctrl.update = 1'b1;
            ST_DC_GO:                 ctrl.div_start = 1'b1;
            ST_PK_GO:
            begin
                ctrl.div_sel = DIV_PK;
                ctrl.div_start = 1'b1;
            end
            ST_PK_WAIT:               ctrl.div_sel = DIV_PK;
            ST_MS_GO:
            begin
                ctrl.div_sel = DIV_MS;
                ctrl.div_start = 1'b1;
            end
            ST_MS_WAIT:               ctrl.div_sel = DIV_MS;
            ST_SQ_GO:                 ctrl.sqrt_start = 1'b1;
            ST_RMS_GO:
            begin
                ctrl.div_sel = DIV_RMS;
                ctrl.div_start = 1'b1;
            end
            ST_RMS_WAIT:              ctrl.div_sel = DIV_RMS;
            ST_PER_GO:
            begin
                ctrl.div_sel = DIV_PER;
                ctrl.div_start = 1'b1;
            end
            ST_PER_WAIT:              ctrl.div_sel = DIV_PER;
            ST_OUT:                   ctrl.load_out = !ov_reg || out_ready;
            default: ;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (out_ready)
            ov_next = 1'b0;
        if (ctrl.load_out)
            ov_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;
endmodule

// ----- hw/rtl/waveform_rms_peak_freq_meter.sv -----
// Waveform meter: sample, edge and tick words each pass the capture, square and
// update states. A report word passes them too, then runs five divisions and a
// square root on one shared restoring divider and one root unit, then holds the
// result in an output register while the next word is accepted. Configuration
// writes are accepted every cycle.
module waveform_rms_peak_freq_meter import wrpf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    wrpf_in_if.sink   in,
    wrpf_out_if.source out,
    wrpf_cfg_if.sink  cfg
);
    ctrl_t ctrl;
    stat_t stat;

    assign cfg.ready = 1'b1;

    wrpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in.valid),
        .in_ready  (in.ready),
        .out_valid (out.valid),
        .out_ready (out.ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    wrpf_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .in_action (in.action),
        .in_sample (in.sample_value),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .o_freq    (out.frequency_count),
        .o_dc      (out.dc_centivolts),
        .o_vpp     (out.vpp_centivolts),
        .o_rms     (out.vrms_centivolts),
        .o_period  (out.sample_period),
        .o_nosig   (out.no_signal)
    );

`ifndef SYNTHESIS
    a_start_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.div_start && ctrl.sqrt_start))
        else $error("divider and root started together");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.update |-> !in.ready)
        else $error("input accepted during update");
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out.valid && !out.ready) |-> !ctrl.load_out)
        else $error("output overwritten");
`endif
endmodule
